// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_CHECK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define AST_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define AST_CHECK(lbl, clk, rstn, prop, msg)
`define AST_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== rtl/lsr_pkg.sv =====
// Shared widths, operation codes and status codes for the LIFO stack.
package lsr_pkg;
  localparam int DATA_W          = 32;
  localparam int KIND_W          = 2;
  localparam int STATUS_W        = 2;
  localparam int DEPTH_W         = 5;
  localparam int STACK_DEPTH_DEF = 16;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_PUSH    = 2'd0;
  localparam kind_t KIND_POP     = 2'd1;
  localparam kind_t KIND_PEEK    = 2'd2;
  localparam kind_t KIND_REVERSE = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_UNDER = 2'd1;
  localparam status_t ST_OVER  = 2'd2;
endpackage

// ===== rtl/lsr_ram.sv =====
// Stack storage: one write port, two registered read ports.
module lsr_ram
  import lsr_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr_a,
  input  logic [AW-1:0]     raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);
  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

// ===== rtl/lifo_stack_with_reverse.sv =====
// Top level: bounded LIFO stack of 32-bit words with push, pop, peek and reverse.
// Push, errors and a reverse of fewer than two entries: result in the cycle after accept.
// Pop and peek: registered memory read in state S_RD, then the result is registered; busy while in S_RD.
// Reverse of n entries: floor(n/2) swaps, each a read, a low write and a high write (S_SW_RD, S_SW_WLO, S_SW_WHI).
// Sync active-low reset empties the stack; storage contents are not cleared.
// Results are strobed on out_valid for one cycle; the receiver cannot stall.
`include "assert_macros.svh"
module lifo_stack_with_reverse
  import lsr_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_data,
  output logic [STATUS_W-1:0]      out_status,
  output logic [DEPTH_W-1:0]       out_depth_now
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD     = 3'd1;
  localparam logic [2:0] S_SW_RD  = 3'd2;
  localparam logic [2:0] S_SW_WLO = 3'd3;
  localparam logic [2:0] S_SW_WHI = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     lo_r, lo_nxt, hi_r, hi_nxt;
  logic [DATA_W-1:0] tmp_r, tmp_nxt;
  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  status_t           status_r, status_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;

  logic              accept, full, empty;
  logic [CW-1:0]     count_dec;
  logic [AW:0]       lo_plus2;
  logic [31:0]       cnt_ext;
  logic              we;
  logic [AW-1:0]     waddr, raddr_a;
  logic [DATA_W-1:0] wdata, rdata_a, rdata_b;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign full      = (count_r == CW'(STACK_DEPTH));
  assign empty     = (count_r == '0);
  assign count_dec = count_r - CW'(1);
  assign lo_plus2  = {1'b0, lo_r} + (AW+1)'(2);

  lsr_ram #(.DEPTH(STACK_DEPTH), .AW(AW)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (hi_r),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_comb begin
    raddr_a = (state_r == S_SW_RD) ? lo_r : count_dec[AW-1:0];
    we      = 1'b0;
    waddr   = count_r[AW-1:0];
    wdata   = in_value;
    unique case (state_r)
      S_IDLE: begin
        we = accept && (in_kind == KIND_PUSH) && !full;
      end
      S_SW_WLO: begin
        we    = 1'b1;
        waddr = lo_r;
        wdata = rdata_b;
      end
      S_SW_WHI: begin
        we    = 1'b1;
        waddr = hi_r;
        wdata = tmp_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    tmp_nxt    = tmp_r;
    valid_nxt  = 1'b0;
    data_nxt   = '0;
    status_nxt = ST_OK;
    cnt_ext    = 32'(count_r);
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            KIND_PUSH: begin
              valid_nxt = 1'b1;
              if (full) begin
                status_nxt = ST_OVER;
              end else begin
                count_nxt = count_r + CW'(1);
              end
            end
            KIND_POP, KIND_PEEK: begin
              if (empty) begin
                valid_nxt  = 1'b1;
                status_nxt = ST_UNDER;
              end else begin
                state_nxt = S_RD;
                if (in_kind == KIND_POP) begin
                  count_nxt = count_dec;
                end
              end
            end
            default: begin
              if (count_r > CW'(1)) begin
                lo_nxt    = '0;
                hi_nxt    = count_dec[AW-1:0];
                state_nxt = S_SW_RD;
              end else begin
                valid_nxt = 1'b1;
              end
            end
          endcase
          cnt_ext = 32'(count_nxt);
        end
      end
      S_RD: begin
        valid_nxt = 1'b1;
        data_nxt  = rdata_a;
        state_nxt = S_IDLE;
      end
      S_SW_RD: begin
        state_nxt = S_SW_WLO;
      end
      S_SW_WLO: begin
        tmp_nxt   = rdata_a;
        state_nxt = S_SW_WHI;
      end
      S_SW_WHI: begin
        lo_nxt = lo_r + AW'(1);
        hi_nxt = hi_r - AW'(1);
        if (lo_plus2 < {1'b0, hi_r}) begin
          state_nxt = S_SW_RD;
        end else begin
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    depth_nxt = cnt_ext[DEPTH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    tmp_r    <= tmp_nxt;
    data_r   <= data_nxt;
    status_r <= status_nxt;
    depth_r  <= depth_nxt;
  end

  assign out_valid     = valid_r;
  assign out_data      = data_r;
  assign out_status    = status_r;
  assign out_depth_now = depth_r;

  `AST_CHECK(a_count_bound, clk, rst_n, count_r <= CW'(STACK_DEPTH), "count beyond depth")
  `AST_CHECK(a_push_ok, clk, rst_n, accept && in_kind == KIND_PUSH && !full |=> out_valid && out_status == ST_OK && count_r == $past(count_r) + CW'(1), "push not completed")
  `AST_CHECK(a_pop_under, clk, rst_n, accept && in_kind == KIND_POP && empty |=> out_valid && out_status == ST_UNDER && $stable(count_r), "underflow not flagged")
  `AST_NEVER(a_swap_quiet, clk, rst_n, (state_r == S_SW_WLO || state_r == S_SW_WHI) && out_valid, "result during swap")
  `AST_CHECK(a_swap_count, clk, rst_n, state_r == S_SW_RD || state_r == S_SW_WLO || state_r == S_SW_WHI |=> $stable(count_r), "count moved during reverse")
endmodule
